// ===== rtl/pcm_downmix_to_16bit_mono_core_macros.svh =====
// ----------------------------------------------------------------------------
// PCM downmix assertion macros
// Property wrappers for the downmix core, clocked on clk, reset by arst_n.
// ----------------------------------------------------------------------------
`ifndef PCM_DOWNMIX_TO_16BIT_MONO_CORE_MACROS_SVH
`define PCM_DOWNMIX_TO_16BIT_MONO_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define PDM_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pdm same-cycle check failed");
`define PDM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pdm next-cycle check failed");
`else
`define PDM_ASSERT_SAME(lbl, ante, cons)
`define PDM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/pdm_pkg.sv =====
// ----------------------------------------------------------------------------
// PCM downmix package
// Register indexes, field widths and shared helpers of the downmix core.
// ----------------------------------------------------------------------------
package pdm_pkg;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;
	localparam int BITS_W     = 6;
	localparam int CHCFG_W    = 5;
	localparam int BPOS_W     = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_BITS   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'b1;

	localparam logic [BITS_W-1:0]  SAMPLE_BITS_RST   = 6'd16;
	localparam logic [CHCFG_W-1:0] CHANNEL_COUNT_RST = 5'd1;

	localparam logic [15:0] HALF_SCALE = 16'h8000;

	// index of the last byte of a sample, byte count clamped to 1..4
	function automatic logic [BPOS_W-1:0] last_byte_idx(input logic [BITS_W-1:0] bits);
		logic [BITS_W:0] nb;
		nb = ({1'b0, bits} + 7'd7) >> 3;
		if (nb == '0)
			last_byte_idx = 2'd0;
		else if (nb > 7'd4)
			last_byte_idx = 2'd3;
		else
			last_byte_idx = BPOS_W'(nb - 7'd1);
	endfunction

endpackage

// ===== rtl/pcm_downmix_to_16bit_mono_core.sv =====
// ----------------------------------------------------------------------------
// PCM downmix to 16-bit mono
// Assembles little-endian PCM samples from a byte stream, sums the offset
// samples of each frame and divides by the channel count with a shared
// restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
//
// channel  handshake              payload
// -------  ---------------------  ---------------------------
// in       in_valid / in_ready    data_byte, data_end
// out      out_valid / out_ready  mono_sample
// cfg      cfg_we                 cfg_index, cfg_data
//
// A byte that does not close a frame is taken and the core stays ready.
// A byte that closes a frame sends the sum to the divider state; the done
// state then loads the output register and returns the core to idle.
// The output register frees the input side: bytes flow while a word waits.
// A finished quotient holds in the divider while the output word is stalled.
// Reset clears the configuration to 16 bits, one channel, and all counters.

`include "pcm_downmix_to_16bit_mono_core_macros.svh"

module pcm_downmix_to_16bit_mono_core #(
	parameter int MAX_CHANNELS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pdm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pdm_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [7:0]                       data_byte,
	input  logic                             data_end,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [15:0]               mono_sample
);
	import pdm_pkg::*;

	localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
	localparam int SUM_W  = 16 + $clog2(MAX_CHANNELS);
	localparam int DCNT_W = $clog2(SUM_W);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic [BITS_W-1:0]   sample_bits_q;
	logic [CHCFG_W-1:0]  channel_count_q;
	logic [BPOS_W-1:0]   byte_pos_q;
	logic [CH_W-1:0]     ch_pos_q;
	logic [7:0]          prev_byte_q;
	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    rem_q;
	logic [SUM_W-1:0]    quo_q;
	logic [CNT_W-1:0]    div_q;
	logic [DCNT_W-1:0]   dcnt_q;
	logic                out_valid_q;
	logic [15:0]         mono_q;

	logic [BPOS_W-1:0]   last_idx;
	logic [CNT_W-1:0]    ch_lim;
	logic [15:0]         mapped;
	logic [SUM_W-1:0]    sum_add;
	logic                sample_done;
	logic                frame_done;
	logic [CNT_W:0]      trial;
	logic                trial_ge;
	logic [CNT_W:0]      trial_diff;
	logic                load_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_bits_q   <= SAMPLE_BITS_RST;
			channel_count_q <= CHANNEL_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SAMPLE_BITS:   sample_bits_q   <= cfg_data;
				REG_CHANNEL_COUNT: channel_count_q <= cfg_data[CHCFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		last_idx = last_byte_idx(sample_bits_q);
		if (channel_count_q == '0)
			ch_lim = CNT_W'(1);
		else if (32'(channel_count_q) > 32'(MAX_CHANNELS))
			ch_lim = CNT_W'(MAX_CHANNELS);
		else
			ch_lim = CNT_W'(channel_count_q);
		if (last_idx == '0)
			mapped = {data_byte, 8'h00};
		else
			mapped = {data_byte, prev_byte_q} + HALF_SCALE;
		sum_add     = sum_q + SUM_W'(mapped);
		sample_done = (byte_pos_q >= last_idx);
		frame_done  = sample_done && (CNT_W'(ch_pos_q) >= (ch_lim - CNT_W'(1)));
		trial       = {rem_q, quo_q[SUM_W-1]};
		trial_ge    = (trial >= {1'b0, div_q});
		trial_diff  = trial - {1'b0, div_q};
		load_out    = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			byte_pos_q  <= '0;
			ch_pos_q    <= '0;
			prev_byte_q <= '0;
			sum_q       <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			div_q       <= '0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
			mono_q      <= '0;
		end else begin
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (frame_done) begin
							rem_q   <= '0;
							quo_q   <= sum_add;
							div_q   <= ch_lim;
							dcnt_q  <= DCNT_W'(SUM_W - 1);
							state_q <= ST_DIV;
						end
						// drop any partial frame at end of data
						if (data_end) begin
							byte_pos_q  <= '0;
							ch_pos_q    <= '0;
							prev_byte_q <= '0;
							sum_q       <= '0;
						end else begin
							prev_byte_q <= data_byte;
							if (sample_done) begin
								byte_pos_q <= '0;
								if (frame_done) begin
									ch_pos_q <= '0;
									sum_q    <= '0;
								end else begin
									ch_pos_q <= ch_pos_q + CH_W'(1);
									sum_q    <= sum_add;
								end
							end else begin
								byte_pos_q <= byte_pos_q + BPOS_W'(1);
							end
						end
					end
				end
				ST_DIV: begin
					rem_q <= trial_ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
					quo_q <= {quo_q[SUM_W-2:0], trial_ge};
					if (dcnt_q == '0)
						state_q <= ST_DONE;
					else
						dcnt_q <= dcnt_q - DCNT_W'(1);
				end
				ST_DONE: begin
					if (load_out) begin
						mono_q  <= quo_q[15:0] ^ HALF_SCALE;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign mono_sample = mono_q;

	`PDM_ASSERT_NEXT(a_frame_starts_div, in_valid && in_ready && frame_done, state_q == ST_DIV)
	`PDM_ASSERT_NEXT(a_div_ends, state_q == ST_DIV && dcnt_q == '0, state_q == ST_DONE)
	`PDM_ASSERT_NEXT(a_done_holds, state_q == ST_DONE && out_valid_q && !out_ready, state_q == ST_DONE && out_valid_q)
	`PDM_ASSERT_NEXT(a_end_clears, in_valid && in_ready && data_end, byte_pos_q == '0 && ch_pos_q == '0 && sum_q == '0)

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCM downmix core testbench
// Streams PCM bytes through the core under a range of sample widths and
// channel counts, predicts each mono sample in a scoreboard and compares it
// with every word the core delivers, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
	import pdm_pkg::*;

	localparam int ITEM_TARGET = 1400;

	class downmix_checker;
		logic [BITS_W-1:0]  sample_bits;
		logic [CHCFG_W-1:0] channel_count;
		logic [1:0]         byte_pos;
		logic [3:0]         chan_pos;
		logic [7:0]         prev_byte;
		logic [19:0]        frame_sum;
		logic signed [15:0] mono_expected[$];
		int                 fails;

		function new();
			sample_bits   = SAMPLE_BITS_RST;
			channel_count = CHANNEL_COUNT_RST;
			byte_pos      = '0;
			chan_pos      = '0;
			prev_byte     = '0;
			frame_sum     = '0;
			fails         = 0;
		endfunction

		function int unsigned sample_bytes();
			int unsigned n;
			n = (int'(sample_bits) + 7) / 8;
			if (n < 1) n = 1;
			if (n > 4) n = 4;
			return n;
		endfunction

		function int unsigned frame_channels();
			int unsigned c;
			c = 32'(channel_count);
			if (c < 1) c = 1;
			if (c > 16) c = 16;
			return c;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
			if (idx == REG_SAMPLE_BITS)
				sample_bits = d[BITS_W-1:0];
			else
				channel_count = d[CHCFG_W-1:0];
		endfunction

		function void take_byte(logic [7:0] b, logic last);
			int unsigned nbytes;
			int unsigned nch;
			logic [15:0] mapped;
			logic [15:0] avg;
			nbytes = sample_bytes();
			nch    = frame_channels();
			if (int'(byte_pos) >= nbytes - 1) begin
				if (nbytes == 1)
					mapped = {b, 8'h00};
				else
					mapped = {b, prev_byte} + HALF_SCALE;
				frame_sum = frame_sum + 20'(mapped);
				byte_pos  = '0;
				if (int'(chan_pos) >= nch - 1) begin
					avg = 16'(int'(frame_sum) / nch);
					mono_expected.push_back(avg - HALF_SCALE);
					chan_pos  = '0;
					frame_sum = '0;
				end else begin
					chan_pos = chan_pos + 4'd1;
				end
			end else begin
				byte_pos = byte_pos + 2'd1;
			end
			prev_byte = b;
			if (last) begin
				byte_pos  = '0;
				chan_pos  = '0;
				prev_byte = '0;
				frame_sum = '0;
			end
		endfunction

		function void check_mono(logic signed [15:0] got);
			logic signed [15:0] want;
			if (mono_expected.size() == 0) begin
				$display("%0t: mono_sample expected none, got %0d", $time, got);
				fails++;
			end else begin
				want = mono_expected.pop_front();
				if (got !== want) begin
					$display("%0t: mono_sample expected %0d, got %0d", $time, want, got);
					fails++;
				end
			end
		endfunction

		function int pending();
			return mono_expected.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [7:0]            data_byte;
	logic                  data_end;
	logic                  out_valid;
	logic                  out_ready;
	logic signed [15:0]    mono_sample;

	downmix_checker chk;
	bit             steady_in;
	int unsigned    items_sent;

	pcm_downmix_to_16bit_mono_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.data_end   (data_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.mono_sample(mono_sample)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Mismatches found");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				chk.write_reg(cfg_index, cfg_data);
			if (in_valid && in_ready)
				chk.take_byte(data_byte, data_end);
			if (out_valid && out_ready)
				chk.check_mono(mono_sample);
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	initial begin
		int unsigned n;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
			out_ready <= 1'b1;
			repeat (n) @(posedge clk);
			n = pick_gap();
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	task automatic send_byte(logic [7:0] b, logic last);
		int unsigned gap;
		gap = steady_in ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		data_end  <= last;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// drain results, then let the divider go quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (chk.pending() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic load_config(bit set_bits, logic [CFG_DATA_W-1:0] bits,
			bit set_ch, logic [CFG_DATA_W-1:0] ch);
		if (set_bits) begin
			cfg_we    <= 1'b1;
			cfg_index <= REG_SAMPLE_BITS;
			cfg_data  <= bits;
			@(posedge clk);
		end
		if (set_ch) begin
			cfg_we    <= 1'b1;
			cfg_index <= REG_CHANNEL_COUNT;
			cfg_data  <= ch;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic random_config();
		int unsigned r;
		logic [CFG_DATA_W-1:0] bits;
		logic [CFG_DATA_W-1:0] ch;
		r = $urandom_range(0, 99);
		if (r < 8)       bits = CFG_DATA_W'($urandom_range(0, 7));
		else if (r < 16) bits = CFG_DATA_W'($urandom_range(33, 63));
		else if (r < 50) bits = CFG_DATA_W'(8 * $urandom_range(1, 4));
		else             bits = CFG_DATA_W'($urandom_range(8, 32));
		r = $urandom_range(0, 99);
		if (r < 8)       ch = '0;
		else if (r < 16) ch = CFG_DATA_W'($urandom_range(17, 31));
		else if (r < 24) ch = 6'd16;
		else if (r < 70) ch = CFG_DATA_W'($urandom_range(1, 4));
		else             ch = CFG_DATA_W'($urandom_range(1, 16));
		if ($urandom_range(0, 9) == 0)
			ch[5] = 1'b1;
		r = $urandom_range(0, 99);
		load_config(r < 85, bits, r >= 70 || r < 55, ch);
	endtask

	task automatic random_frames();
		int unsigned budget;
		int unsigned done_here;
		int unsigned flen;
		int unsigned cut;
		int unsigned mode;
		int unsigned j;
		logic [7:0]  b;
		logic        last;
		steady_in = ($urandom_range(0, 4) == 0);
		budget    = $urandom_range(16, 120);
		done_here = 0;
		while (done_here < budget) begin
			flen = chk.sample_bytes() * chk.frame_channels();
			mode = $urandom_range(0, 9);
			cut  = flen;
			if ($urandom_range(0, 9) == 0)
				cut = $urandom_range(1, flen);
			for (j = 0; j < cut; j++) begin
				case (mode)
					7: b = 8'hff;
					8: b = 8'h00;
					9: b = $urandom_range(0, 1) ? 8'hff : 8'h00;
					default: b = 8'($urandom_range(0, 255));
				endcase
				last = ($urandom_range(0, 49) == 0);
				if (j == cut - 1) begin
					if (cut < flen)
						last = ($urandom_range(0, 9) < 7);
					else if (done_here + cut >= budget)
						last = 1'($urandom_range(0, 1));
				end
				send_byte(b, last);
			end
			done_here += cut;
		end
		steady_in = 1'b0;
	endtask

	initial begin
		chk        = new();
		steady_in  = 1'b0;
		items_sent = 0;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = REG_SAMPLE_BITS;
		cfg_data   = '0;
		in_valid   = 1'b0;
		data_byte  = '0;
		data_end   = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: 16-bit mono, full scale both ways, then a dropped half sample
		send_byte(8'h00, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h7f, 1'b0);
		send_byte(8'h12, 1'b1);
		send_byte(8'hab, 1'b0);
		settle();

		// narrow the sample width while a sample is half done
		load_config(1'b1, 6'd8, 1'b0, '0);
		send_byte(8'hcd, 1'b0);
		settle();

		load_config(1'b1, 6'd0, 1'b1, 6'd0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		settle();

		// 24-bit stereo, end mark on the byte that closes the frame
		load_config(1'b1, 6'd24, 1'b1, 6'd2);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h7f, 1'b1);
		settle();

		load_config(1'b1, 6'd40, 1'b1, 6'd1);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b1);

		while (items_sent < ITEM_TARGET) begin
			settle();
			random_config();
			random_frames();
		end

		in_valid <= 1'b0;
		while (chk.pending() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (chk.fails == 0 && chk.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
